FILE: design/rie_pkg.sv
// shared types, register codes and saturating arithmetic helpers of the inertia estimator
package rie_pkg;

  localparam int NUM_CFG    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_J_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_J_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_I_FLOOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_A_FLOOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COV0    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd7;

  localparam logic [16:0] FORGET_RST  = 17'd65208;
  localparam logic [27:0] KT_RST      = 28'd587203;
  localparam logic [47:0] J_LOW_RST   = 48'd17592186;
  localparam logic [47:0] J_HIGH_RST  = 48'd175921860444;
  localparam logic [30:0] I_FLOOR_RST = 31'd13107;
  localparam logic [30:0] A_FLOOR_RST = 31'd327680;
  localparam logic [15:0] COV0_RST    = 16'd1000;

  localparam logic [16:0] LAMBDA_MIN = 17'd58982;
  localparam logic [16:0] LAMBDA_MAX = 17'd65536;
  localparam logic [63:0] DEN_EPS    = 64'd1048576;
  localparam logic [63:0] T1_EPS     = 64'd16;
  localparam logic [63:0] ONE_Q16    = 64'd65536;

  // product and quotient shifts
  localparam logic [5:0] SH_Q16 = 6'd16;
  localparam logic [5:0] SH_Q24 = 6'd24;
  localparam logic [5:0] SH_Q40 = 6'd40;
  localparam int         DSH_K  = 40;
  localparam int         DSH_P  = 16;
  localparam int         DSH_J  = 44;
  localparam logic [6:0] DIV_STEPS_K = 7'(64 + DSH_K - 1);
  localparam logic [6:0] DIV_STEPS_P = 7'(64 + DSH_P - 1);
  localparam logic [6:0] DIV_STEPS_J = 7'(64 + DSH_J - 1);

  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

  // request operations
  localparam logic OP_UPDATE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // result status codes
  localparam logic [2:0] STAT_UPDATED     = 3'd0;
  localparam logic [2:0] STAT_DISABLED    = 3'd1;
  localparam logic [2:0] STAT_LOW_CURRENT = 3'd2;
  localparam logic [2:0] STAT_LOW_ACCEL   = 3'd3;
  localparam logic [2:0] STAT_SMALL_DEN   = 3'd4;
  localparam logic [2:0] STAT_SATURATED   = 3'd5;
  localparam logic [2:0] STAT_RESTARTED   = 3'd6;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] current_q;
    logic signed [31:0] speed;
    logic signed [31:0] accel;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               estimate_valid;
    logic [47:0]        inertia;
    logic signed [47:0] damping;
    logic signed [47:0] load_ratio;
    logic signed [47:0] fit_error;
    logic [31:0]        updates_done;
  } out_t;

  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // signed value of a magnitude, saturated; msb of result is the overflow flag
  function automatic logic [64:0] to_sat(input logic [127:0] m, input logic neg);
    logic [64:0] r;
    if (neg) begin
      if (m <= {64'd0, SAT_MIN}) r = {1'b0, 64'd0 - m[63:0]};
      else r = {1'b1, SAT_MIN};
    end else begin
      if (m <= {64'd0, SAT_MAX}) r = {1'b0, m[63:0]};
      else r = {1'b1, SAT_MAX};
    end
    return r;
  endfunction

  function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic sub);
    logic [64:0] s;
    logic [64:0] r;
    s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
    if (s[64] != s[63]) r = {1'b1, s[64] ? SAT_MIN : SAT_MAX};
    else r = {1'b0, s[63:0]};
    return r;
  endfunction

  function automatic logic [48:0] clamp48(input logic [63:0] x);
    logic [48:0] r;
    if (x[63:47] == {17{x[63]}}) r = {1'b0, x[47:0]};
    else r = {1'b1, x[63] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF};
    return r;
  endfunction

  // floor of the mean of two signed words
  function automatic logic [63:0] avg2(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    return s[64:1];
  endfunction

  function automatic logic [63:0] sext48(input logic [47:0] x);
    return {{16{x[47]}}, x};
  endfunction

endpackage

FILE: design/rls_inertia_estimator_unit.sv
// three-parameter forgetting least squares inertia estimator, one shared mac and divider
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+-----------------------------
//  in       | in_valid, in_ready, in_data               | sample or restart request
//  out      | out_valid, out_ready, out_data            | one result per request
//  cfg      | cfg_we, cfg_index, cfg_wdata              | register write, no wait
//
// an applied update spends most of its time in the one-bit-per-cycle divider (up to 13
// quotients of 80 to 108 steps); each product is formed on the 32x32 partial-product
// multiplier. disabled, restart and skipped-by-input requests go straight from idle
// to done. in_ready is high only while the sequencer is idle; a finished result waits
// in the output register while the next request is taken. reset is synchronous.
module rls_inertia_estimator_unit
  import rie_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NEXT = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DFIN = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  localparam logic [3:0] PH_YH  = 4'd0;
  localparam logic [3:0] PH_V   = 4'd1;
  localparam logic [3:0] PH_DEN = 4'd2;
  localparam logic [3:0] PH_K   = 4'd3;
  localparam logic [3:0] PH_TH  = 4'd4;
  localparam logic [3:0] PH_P   = 4'd5;
  localparam logic [3:0] PH_AVG = 4'd6;
  localparam logic [3:0] PH_DER = 4'd7;
  localparam logic [3:0] PH_DB  = 4'd8;

  localparam logic [63:0] COV_RST_WORD = {8'd0, COV0_RST, 40'd0};

  // configuration
  logic [16:0] forget_r;
  logic [27:0] kt_r;
  logic [47:0] jlow_r, jhigh_r;
  logic [30:0] ifloor_r, afloor_r;
  logic [15:0] cov0_r;
  logic        enable_r;

  // sequencer and state
  logic [2:0]  state_r, state_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [31:0] iq_r, iq_nxt, spd_r, spd_nxt, acl_r, acl_nxt;
  logic [47:0] theta_r [3];
  logic [47:0] theta_nxt [3];
  logic [63:0] cov_r [9];
  logic [63:0] cov_nxt [9];
  logic [63:0] v_r [3];
  logic [63:0] v_nxt [3];
  logic [63:0] k_r [3];
  logic [63:0] k_nxt [3];
  logic [63:0] den_r, den_nxt, jq_r, jq_nxt;
  logic [47:0] err_r, err_nxt;
  logic        ovf_r, ovf_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic        valid_r, valid_nxt;
  logic [47:0] est_j_r, est_j_nxt, est_b_r, est_b_nxt, est_ld_r, est_ld_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  // shared multiply-accumulate unit
  logic [63:0]  acc_r, acc_nxt, mx_r, mx_nxt, my_r, my_nxt, mres_r, mres_nxt;
  logic         mneg_r, mneg_nxt, msub_r, msub_nxt, movf_r, movf_nxt;
  logic [5:0]   ms_r, ms_nxt;
  logic [1:0]   mcnt_r, mcnt_nxt;
  logic [127:0] prod_r, prod_nxt;

  // shared restoring divider
  logic [127:0] num_r, num_nxt, q_r, q_nxt;
  logic [63:0]  rem_r, rem_nxt, dm_r, dm_nxt;
  logic         dneg_r, dneg_nxt;
  logic [6:0]   dcnt_r, dcnt_nxt;

  // launch requests from the sequencer
  logic         mac_go, mac_init, mac_sub;
  logic [63:0]  mac_x, mac_y, mac_iv;
  logic [5:0]   mac_s;
  logic         div_go;
  logic [63:0]  div_n, div_d;
  logic [6:0]   div_steps;
  logic         fin, inval;

  logic         in_fire;
  logic [16:0]  lam;
  logic [63:0]  phi_i, phi_j;
  logic [3:0]   cidx;
  logic [31:0]  iq_mag, acl_mag;
  logic         extreme;
  logic [31:0]  pp_a, pp_b;
  logic [63:0]  pp;
  logic [127:0] pp_sh, rnd;
  logic [64:0]  rsat, asat, dsat, esat;
  logic [48:0]  ecl, bcl, ldcl;
  logic [64:0]  rsh;
  logic [63:0]  dres;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign lam = (forget_r < LAMBDA_MIN) ? LAMBDA_MIN :
               (forget_r > LAMBDA_MAX) ? LAMBDA_MAX : forget_r;
  assign cidx = 4'({i_r, 1'b0}) + 4'(i_r) + 4'(j_r);

  assign iq_mag  = in_data.current_q[31] ? (32'd0 - in_data.current_q) : in_data.current_q;
  assign acl_mag = in_data.accel[31] ? (32'd0 - in_data.accel) : in_data.accel;
  assign extreme = in_data.current_q == 32'h8000_0000 || in_data.current_q == 32'h7FFF_FFFF ||
                   in_data.speed == 32'h8000_0000 || in_data.speed == 32'h7FFF_FFFF ||
                   in_data.accel == 32'h8000_0000 || in_data.accel == 32'h7FFF_FFFF;

  // regressor (iq, w, 1)
  always_comb begin
    case (i_r)
      2'd0:    phi_i = {{32{iq_r[31]}}, iq_r};
      2'd1:    phi_i = {{32{spd_r[31]}}, spd_r};
      default: phi_i = ONE_Q16;
    endcase
    case (j_r)
      2'd0:    phi_j = {{32{iq_r[31]}}, iq_r};
      2'd1:    phi_j = {{32{spd_r[31]}}, spd_r};
      default: phi_j = ONE_Q16;
    endcase
  end

  // datapath pieces of the shared units
  assign pp_a  = mcnt_r[1] ? mx_r[63:32] : mx_r[31:0];
  assign pp_b  = mcnt_r[0] ? my_r[63:32] : my_r[31:0];
  assign pp    = 64'(pp_a) * 64'(pp_b);
  assign pp_sh = {64'd0, pp} << (7'(mcnt_r[0]) + 7'(mcnt_r[1])) * 7'd32;
  assign rnd   = (prod_r + (128'd1 << (ms_r - 6'd1))) >> ms_r;
  assign rsat  = to_sat(rnd, mneg_r);
  assign asat  = sat_add(acc_r, mres_r, msub_r);
  assign rsh   = {rem_r, num_r[127]};
  assign dsat  = to_sat(q_r, dneg_r);
  assign dres  = (dm_r == 64'd0) ? 64'd0 : dsat[63:0];
  assign esat  = sat_add({{24{acl_r[31]}}, acl_r, 8'd0}, asat[63:0], 1'b1);
  assign ecl   = clamp48(esat[63:0]);
  assign bcl   = clamp48(asat[63:0]);
  assign ldcl  = clamp48(64'd0 - sext48(theta_r[2]));

  always_comb begin
    state_nxt = state_r;   phase_nxt = phase_r;   i_nxt = i_r;   j_nxt = j_r;
    iq_nxt = iq_r;         spd_nxt = spd_r;       acl_nxt = acl_r;
    theta_nxt = theta_r;   cov_nxt = cov_r;       v_nxt = v_r;   k_nxt = k_r;
    den_nxt = den_r;       jq_nxt = jq_r;         err_nxt = err_r;
    ovf_nxt = ovf_r;       stat_nxt = stat_r;     valid_nxt = valid_r;
    est_j_nxt = est_j_r;   est_b_nxt = est_b_r;   est_ld_nxt = est_ld_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;
    acc_nxt = acc_r;  mx_nxt = mx_r;  my_nxt = my_r;  mres_nxt = mres_r;
    mneg_nxt = mneg_r;  msub_nxt = msub_r;  movf_nxt = movf_r;  ms_nxt = ms_r;
    mcnt_nxt = mcnt_r;  prod_nxt = prod_r;
    num_nxt = num_r;  q_nxt = q_r;  rem_nxt = rem_r;  dm_nxt = dm_r;
    dneg_nxt = dneg_r;  dcnt_nxt = dcnt_r;
    mac_go = 1'b0;  mac_init = 1'b0;  mac_sub = 1'b0;
    mac_x = '0;  mac_y = '0;  mac_iv = '0;  mac_s = SH_Q16;
    div_go = 1'b0;  div_n = '0;  div_d = '0;  div_steps = '0;
    fin = 1'b0;  inval = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          err_nxt = '0;
          ovf_nxt = 1'b0;
          iq_nxt  = in_data.current_q;
          spd_nxt = in_data.speed;
          acl_nxt = in_data.accel;
          state_nxt = ST_DONE;
          if (!enable_r) begin
            stat_nxt = STAT_DISABLED;
          end else if (in_data.operation == OP_RESTART) begin
            stat_nxt = STAT_RESTARTED;
            theta_nxt = '{default: '0};
            cov_nxt = '{default: '0};
            cov_nxt[0] = {8'd0, cov0_r, 40'd0};
            cov_nxt[4] = {8'd0, cov0_r, 40'd0};
            cov_nxt[8] = {8'd0, cov0_r, 40'd0};
            valid_nxt = 1'b0;
            est_j_nxt = '0;
            est_b_nxt = '0;
            est_ld_nxt = '0;
            cnt_nxt = '0;
          end else if (extreme) begin
            stat_nxt = STAT_SATURATED;
          end else if (iq_mag < {1'b0, ifloor_r}) begin
            stat_nxt = STAT_LOW_CURRENT;
          end else if (acl_mag < {1'b0, afloor_r}) begin
            stat_nxt = STAT_LOW_ACCEL;
          end else begin
            phase_nxt = PH_YH;
            i_nxt = 2'd0;
            j_nxt = 2'd0;
            state_nxt = ST_NEXT;
          end
        end
      end

      ST_NEXT: begin
        case (phase_r)
          PH_YH: begin
            mac_go = 1'b1;  mac_x = phi_i;  mac_y = sext48(theta_r[i_r]);
            mac_s = SH_Q16;  mac_init = (i_r == 2'd0);
          end
          PH_V: begin
            mac_go = 1'b1;  mac_x = cov_r[cidx];  mac_y = phi_j;
            mac_s = SH_Q16;  mac_init = (j_r == 2'd0);
          end
          PH_DEN: begin
            mac_go = 1'b1;  mac_x = phi_i;  mac_y = v_r[i_r];  mac_s = SH_Q16;
            mac_init = (i_r == 2'd0);  mac_iv = {23'd0, lam, 24'd0};
          end
          PH_K: begin
            div_go = 1'b1;  div_n = v_r[i_r];  div_d = den_r;  div_steps = DIV_STEPS_K;
          end
          PH_TH: begin
            mac_go = 1'b1;  mac_x = k_r[i_r];  mac_y = sext48(err_r);  mac_s = SH_Q40;
            mac_init = 1'b1;  mac_iv = sext48(theta_r[i_r]);
          end
          PH_P: begin
            mac_go = 1'b1;  mac_x = k_r[i_r];  mac_y = v_r[j_r];  mac_s = SH_Q40;
            mac_init = 1'b1;  mac_iv = cov_r[cidx];  mac_sub = 1'b1;
          end
          PH_AVG: begin
            cov_nxt[1] = avg2(cov_r[1], cov_r[3]);
            cov_nxt[3] = avg2(cov_r[1], cov_r[3]);
            cov_nxt[2] = avg2(cov_r[2], cov_r[6]);
            cov_nxt[6] = avg2(cov_r[2], cov_r[6]);
            cov_nxt[5] = avg2(cov_r[5], cov_r[7]);
            cov_nxt[7] = avg2(cov_r[5], cov_r[7]);
            phase_nxt = PH_DER;
          end
          PH_DER: begin
            if (mag64(sext48(theta_r[0])) < T1_EPS) begin
              fin = 1'b1;
              inval = 1'b1;
            end else begin
              div_go = 1'b1;  div_n = {36'd0, kt_r};  div_d = sext48(theta_r[0]);
              div_steps = DIV_STEPS_J;
            end
          end
          PH_DB: begin
            mac_go = 1'b1;  mac_x = 64'd0 - sext48(theta_r[1]);  mac_y = jq_r;
            mac_s = SH_Q24;  mac_init = 1'b1;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      ST_MUL: begin
        prod_nxt = prod_r + pp_sh;
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) state_nxt = ST_RND;
      end

      ST_RND: begin
        mres_nxt = rsat[63:0];
        movf_nxt = rsat[64];
        state_nxt = ST_ACC;
      end

      ST_ACC: begin
        acc_nxt = asat[63:0];
        state_nxt = ST_NEXT;
        case (phase_r)
          PH_YH: begin
            if (i_r == 2'd2) begin
              err_nxt = ecl[47:0];
              phase_nxt = PH_V;
              i_nxt = 2'd0;
              j_nxt = 2'd0;
            end else begin
              i_nxt = i_r + 2'd1;
            end
          end
          PH_V: begin
            ovf_nxt = ovf_r | movf_r | asat[64];
            if (j_r == 2'd2) begin
              v_nxt[i_r] = asat[63:0];
              j_nxt = 2'd0;
              if (i_r == 2'd2) begin
                phase_nxt = PH_DEN;
                i_nxt = 2'd0;
              end else begin
                i_nxt = i_r + 2'd1;
              end
            end else begin
              j_nxt = j_r + 2'd1;
            end
          end
          PH_DEN: begin
            ovf_nxt = ovf_r | movf_r | asat[64];
            if (i_r == 2'd2) begin
              den_nxt = asat[63:0];
              if (ovf_r | movf_r | asat[64]) begin
                stat_nxt = STAT_SATURATED;
                state_nxt = ST_DONE;
              end else if (mag64(asat[63:0]) < DEN_EPS) begin
                stat_nxt = STAT_SMALL_DEN;
                state_nxt = ST_DONE;
              end else begin
                phase_nxt = PH_K;
                i_nxt = 2'd0;
              end
            end else begin
              i_nxt = i_r + 2'd1;
            end
          end
          PH_TH: begin
            theta_nxt[i_r] = bcl[47:0];
            if (i_r == 2'd2) begin
              phase_nxt = PH_P;
              i_nxt = 2'd0;
              j_nxt = 2'd0;
            end else begin
              i_nxt = i_r + 2'd1;
            end
          end
          PH_P: begin
            // then divide the difference by lambda
            div_go = 1'b1;  div_n = asat[63:0];  div_d = {47'd0, lam};
            div_steps = DIV_STEPS_P;
          end
          PH_DB: begin
            fin = 1'b1;
            if (movf_r | asat[64] | bcl[48] | ldcl[48]) begin
              inval = 1'b1;
            end else begin
              valid_nxt = 1'b1;
              est_j_nxt = jq_r[47:0];
              est_b_nxt = bcl[47:0];
              est_ld_nxt = ldcl[47:0];
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      ST_DIV: begin
        if (rsh >= {1'b0, dm_r}) begin
          rem_nxt = 64'(rsh - {1'b0, dm_r});
          q_nxt = {q_r[126:0], 1'b1};
        end else begin
          rem_nxt = rsh[63:0];
          q_nxt = {q_r[126:0], 1'b0};
        end
        num_nxt = {num_r[126:0], 1'b0};
        dcnt_nxt = dcnt_r - 7'd1;
        if (dcnt_r == 7'd0) state_nxt = ST_DFIN;
      end

      ST_DFIN: begin
        state_nxt = ST_NEXT;
        case (phase_r)
          PH_K: begin
            k_nxt[i_r] = dres;
            if (i_r == 2'd2) begin
              phase_nxt = PH_TH;
              i_nxt = 2'd0;
            end else begin
              i_nxt = i_r + 2'd1;
            end
          end
          PH_P: begin
            cov_nxt[cidx] = dres;
            if (j_r == 2'd2) begin
              j_nxt = 2'd0;
              if (i_r == 2'd2) begin
                phase_nxt = PH_AVG;
                i_nxt = 2'd0;
              end else begin
                i_nxt = i_r + 2'd1;
              end
            end else begin
              j_nxt = j_r + 2'd1;
            end
          end
          PH_DER: begin
            jq_nxt = dres;
            if ($signed(dres) < $signed({16'd0, jlow_r}) ||
                $signed(dres) > $signed({16'd0, jhigh_r})) begin
              fin = 1'b1;
              inval = 1'b1;
            end else begin
              phase_nxt = PH_DB;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.status = stat_r;
          out_data_nxt.estimate_valid = valid_r;
          out_data_nxt.inertia = est_j_r;
          out_data_nxt.damping = est_b_r;
          out_data_nxt.load_ratio = est_ld_r;
          out_data_nxt.fit_error = err_r;
          out_data_nxt.updates_done = cnt_r;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (mac_go) begin
      mx_nxt   = mag64(mac_x);
      my_nxt   = mag64(mac_y);
      mneg_nxt = mac_x[63] ^ mac_y[63];
      ms_nxt   = mac_s;
      msub_nxt = mac_sub;
      prod_nxt = '0;
      mcnt_nxt = 2'd0;
      if (mac_init) acc_nxt = mac_iv;
      state_nxt = ST_MUL;
    end

    if (div_go) begin
      dm_nxt   = mag64(div_d);
      num_nxt  = {mag64(div_n), 64'd0};
      rem_nxt  = '0;
      q_nxt    = '0;
      dneg_nxt = div_n[63] ^ div_d[63];
      dcnt_nxt = div_steps;
      state_nxt = ST_DIV;
    end

    if (fin) begin
      cnt_nxt = cnt_r + 32'd1;
      stat_nxt = STAT_UPDATED;
      state_nxt = ST_DONE;
      if (inval) begin
        valid_nxt = 1'b0;
        est_j_nxt = '0;
        est_b_nxt = '0;
        est_ld_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      forget_r <= FORGET_RST;
      kt_r     <= KT_RST;
      jlow_r   <= J_LOW_RST;
      jhigh_r  <= J_HIGH_RST;
      ifloor_r <= I_FLOOR_RST;
      afloor_r <= A_FLOOR_RST;
      cov0_r   <= COV0_RST;
      enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORGET:  forget_r <= cfg_wdata[16:0];
        CFG_KT:      kt_r     <= cfg_wdata[27:0];
        CFG_J_LOW:   jlow_r   <= cfg_wdata;
        CFG_J_HIGH:  jhigh_r  <= cfg_wdata;
        CFG_I_FLOOR: ifloor_r <= cfg_wdata[30:0];
        CFG_A_FLOOR: afloor_r <= cfg_wdata[30:0];
        CFG_COV0:    cov0_r   <= cfg_wdata[15:0];
        CFG_ENABLE:  enable_r <= cfg_wdata[0];
        default:     enable_r <= enable_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_YH;
      i_r         <= 2'd0;
      j_r         <= 2'd0;
      mcnt_r      <= 2'd0;
      dcnt_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      theta_r     <= '{default: '0};
      cov_r       <= '{COV_RST_WORD, '0, '0, '0, COV_RST_WORD, '0, '0, '0, COV_RST_WORD};
      valid_r     <= 1'b0;
      est_j_r     <= '0;
      est_b_r     <= '0;
      est_ld_r    <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      mcnt_r      <= mcnt_nxt;
      dcnt_r      <= dcnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      theta_r     <= theta_nxt;
      cov_r       <= cov_nxt;
      valid_r     <= valid_nxt;
      est_j_r     <= est_j_nxt;
      est_b_r     <= est_b_nxt;
      est_ld_r    <= est_ld_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iq_r       <= iq_nxt;
    spd_r      <= spd_nxt;
    acl_r      <= acl_nxt;
    v_r        <= v_nxt;
    k_r        <= k_nxt;
    den_r      <= den_nxt;
    jq_r       <= jq_nxt;
    err_r      <= err_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
    acc_r      <= acc_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    mres_r     <= mres_nxt;
    mneg_r     <= mneg_nxt;
    msub_r     <= msub_nxt;
    movf_r     <= movf_nxt;
    ms_r       <= ms_nxt;
    prod_r     <= prod_nxt;
    num_r      <= num_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    dm_r       <= dm_nxt;
    dneg_r     <= dneg_nxt;
  end

  // an invalid estimate never leaves stale derived values behind
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> (est_j_r == '0 && est_b_r == '0 && est_ld_r == '0))
    else $error("derived values nonzero while estimate invalid");

  // an enabled restart clears the update count
  a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && enable_r && in_data.operation == OP_RESTART) |=> cnt_r == '0)
    else $error("restart did not clear update count");

  // the multiplier always goes on to rounding after its last partial product
  a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && mcnt_r == 2'd3) |=> state_r == ST_RND)
    else $error("multiply sequence length broken");

  // a new result is only ever loaded from the done state
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid_r && !out_ready)) |-> $past(state_r) == ST_DONE)
    else $error("result loaded outside done state");

endmodule
